@@ hdl/ycc_pkg.sv @@
// Package for the 4:2:2 YCbCr to RGB converter: Q12 coefficients, datapath types
// and the channel saturation function. No dependencies.
package ycc_pkg;

    localparam int FRAC_BITS = 12;

    typedef logic signed [8:0]  off_t;
    typedef logic signed [23:0] prod_t;
    typedef logic [7:0]         chan_t;

    localparam logic signed [14:0] K_LUMA     = 15'sd4768;
    localparam logic signed [14:0] K_CB_BLUE  = 15'sd8266;
    localparam logic signed [14:0] K_CR_GREEN = 15'sd3330;
    localparam logic signed [14:0] K_CB_GREEN = 15'sd1602;
    localparam logic signed [14:0] K_CR_RED   = 15'sd6537;

    localparam logic [8:0] LUMA_BASE   = 9'd16;
    localparam logic [8:0] CHROMA_BASE = 9'd128;
    localparam chan_t      CHAN_MAX    = 8'd255;

    // floor by 2^12 then clamp to 0..255
    function automatic chan_t sat_q12(input prod_t acc);
        chan_t res;
        if (acc[23])
        begin
            res = '0;
        end
        else if (|acc[22:FRAC_BITS+8])
        begin
            res = CHAN_MAX;
        end
        else
        begin
            res = acc[FRAC_BITS+7:FRAC_BITS];
        end
        return res;
    endfunction

endpackage

@@ hdl/ycbcr422_to_rgb_converter_top.sv @@
// Top level of the 4:2:2 YCbCr to RGB (BT.601 studio range) converter.
// Depends on ycc_pkg and ycc_pixel.
//
// Takes one pixel pair per beat and gives two saturated 8-bit RGB pixels per beat.
// Four register stages (offsets, products, sums, saturation): an accepted beat passes
// through them in that order to the outputs, and one beat is taken every cycle
// while the output side is ready. The whole pipe holds while a result waits unaccepted.
// No state beyond the pipe, so reset only clears the valid bits.
module ycbcr422_to_rgb_converter_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] luma_first,
    input  logic [7:0] chroma_blue,
    input  logic [7:0] luma_second,
    input  logic [7:0] chroma_red,
    input  logic       last_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] blue_first,
    output logic [7:0] green_first,
    output logic [7:0] red_first,
    output logic [7:0] blue_second,
    output logic [7:0] green_second,
    output logic [7:0] red_second,
    output logic       last_out
);

    logic adv;
    logic [3:0] v_reg;
    logic [3:0] v_next;
    logic [3:0] last_reg;

    ycc_pkg::off_t  yo1_reg;
    ycc_pkg::off_t  yo2_reg;
    ycc_pkg::off_t  bo_reg;
    ycc_pkg::off_t  ro_reg;
    ycc_pkg::prod_t ys1_reg;
    ycc_pkg::prod_t ys2_reg;
    ycc_pkg::prod_t cb_blue_reg;
    ycc_pkg::prod_t cr_green_reg;
    ycc_pkg::prod_t cb_green_reg;
    ycc_pkg::prod_t cr_red_reg;

    assign adv      = !v_reg[3] || out_ready;
    assign in_ready = adv;
    assign v_next   = {v_reg[2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg     <= {last_reg[2:0], last_in};
            yo1_reg      <= ycc_pkg::off_t'({1'b0, luma_first}) - ycc_pkg::LUMA_BASE;
            yo2_reg      <= ycc_pkg::off_t'({1'b0, luma_second}) - ycc_pkg::LUMA_BASE;
            bo_reg       <= ycc_pkg::off_t'({1'b0, chroma_blue}) - ycc_pkg::CHROMA_BASE;
            ro_reg       <= ycc_pkg::off_t'({1'b0, chroma_red}) - ycc_pkg::CHROMA_BASE;
            ys1_reg      <= ycc_pkg::prod_t'(yo1_reg) * ycc_pkg::prod_t'(ycc_pkg::K_LUMA);
            ys2_reg      <= ycc_pkg::prod_t'(yo2_reg) * ycc_pkg::prod_t'(ycc_pkg::K_LUMA);
            cb_blue_reg  <= ycc_pkg::prod_t'(bo_reg) * ycc_pkg::prod_t'(ycc_pkg::K_CB_BLUE);
            cr_green_reg <= ycc_pkg::prod_t'(ro_reg) * ycc_pkg::prod_t'(ycc_pkg::K_CR_GREEN);
            cb_green_reg <= ycc_pkg::prod_t'(bo_reg) * ycc_pkg::prod_t'(ycc_pkg::K_CB_GREEN);
            cr_red_reg   <= ycc_pkg::prod_t'(ro_reg) * ycc_pkg::prod_t'(ycc_pkg::K_CR_RED);
        end
    end

    ycc_pixel u_pix_first (
        .clk      (clk),
        .adv      (adv),
        .ys       (ys1_reg),
        .cb_blue  (cb_blue_reg),
        .cr_green (cr_green_reg),
        .cb_green (cb_green_reg),
        .cr_red   (cr_red_reg),
        .blue     (blue_first),
        .green    (green_first),
        .red      (red_first)
    );

    ycc_pixel u_pix_second (
        .clk      (clk),
        .adv      (adv),
        .ys       (ys2_reg),
        .cb_blue  (cb_blue_reg),
        .cr_green (cr_green_reg),
        .cb_green (cb_green_reg),
        .cr_red   (cr_red_reg),
        .blue     (blue_second),
        .green    (green_second),
        .red      (red_second)
    );

    assign out_valid = v_reg[3];
    assign last_out  = last_reg[3];

    // a waiting result holds the whole pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // stage 3 beat reaches the output on an advance
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && v_reg[2] |=> out_valid)
        else $error("beat lost between sum and output stage");

    // valid bits frozen during a stall
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> v_reg == $past(v_reg))
        else $error("valid bits moved during stall");

    // accepted beat enters stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v_reg[0])
        else $error("accepted beat not captured");

endmodule

@@ hdl/ycc_pixel.sv @@
// One output pixel: Q12 channel sums (stage 3) and saturated channel registers (stage 4).
// Depends on ycc_pkg.
module ycc_pixel (
    input  logic           clk,
    input  logic           adv,
    input  ycc_pkg::prod_t ys,
    input  ycc_pkg::prod_t cb_blue,
    input  ycc_pkg::prod_t cr_green,
    input  ycc_pkg::prod_t cb_green,
    input  ycc_pkg::prod_t cr_red,
    output ycc_pkg::chan_t blue,
    output ycc_pkg::chan_t green,
    output ycc_pkg::chan_t red
);

    ycc_pkg::prod_t blue_sum_reg;
    ycc_pkg::prod_t green_sum_reg;
    ycc_pkg::prod_t red_sum_reg;
    ycc_pkg::chan_t blue_reg;
    ycc_pkg::chan_t green_reg;
    ycc_pkg::chan_t red_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            blue_sum_reg  <= ys + cb_blue;
            green_sum_reg <= ys - cr_green - cb_green;
            red_sum_reg   <= ys + cr_red;
            blue_reg      <= ycc_pkg::sat_q12(blue_sum_reg);
            green_reg     <= ycc_pkg::sat_q12(green_sum_reg);
            red_reg       <= ycc_pkg::sat_q12(red_sum_reg);
        end
    end

    assign blue  = blue_reg;
    assign green = green_reg;
    assign red   = red_reg;

endmodule
